// ----- hdl/cpg_pkg.sv -----
package cpg_pkg;

  localparam int COORD_BITS = 12;
  localparam int OFF_W      = COORD_BITS + 2;
  localparam int DEC_W      = COORD_BITS + 4;
  localparam int PIX_W      = 14;
  localparam int FIELD_W    = 12;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic signed [DEC_W-1:0] DEC_INIT   = DEC_W'(3);
  localparam logic signed [DEC_W-1:0] DEC_INC_NEG = DEC_W'(6);
  localparam logic signed [DEC_W-1:0] DEC_INC_POS = DEC_W'(10);

  // one point set handed from the step unit to the pixel serializer
  typedef struct packed {
    logic                        done;
    logic [COORD_BITS-1:0]       cx;
    logic [COORD_BITS-1:0]       cy;
    logic signed [OFF_W-1:0]     a;
    logic signed [OFF_W-1:0]     b;
  } job_t;

endpackage

// ----- hdl/cpg_step.sv -----
module cpg_step
  import cpg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               acc,
  input  logic               cmd,
  input  logic [FIELD_W-1:0] center_x,
  input  logic [FIELD_W-1:0] center_y,
  input  logic [FIELD_W-1:0] radius,
  input  logic               fill,
  output logic               job_load,
  output job_t               job
);

  typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_LOOP} phase_t;

  logic [COORD_BITS-1:0]   center_col, center_col_next;
  logic [COORD_BITS-1:0]   center_row, center_row_next;
  logic                    fill_mode, fill_mode_next;
  logic signed [OFF_W-1:0] col_offset, col_offset_next;
  logic signed [OFF_W-1:0] row_offset, row_offset_next;
  logic signed [OFF_W-1:0] inner_row, inner_row_next;
  logic signed [DEC_W-1:0] decision, decision_next;
  phase_t                  phase, phase_next;

  logic signed [DEC_W-1:0] col_w, row_w, dec_adv;
  logic signed [OFF_W-1:0] col_adv, row_adv, inner_inc;
  logic [COORD_BITS-1:0]   r_c;

  assign job_load = acc && (cmd == CMD_STEP);

  // midpoint decision advance from the current offsets
  always_comb begin
    col_w   = DEC_W'(col_offset);
    row_w   = DEC_W'(row_offset);
    col_adv = col_offset + OFF_W'(1);
    if (decision[DEC_W-1]) begin
      dec_adv = decision + (col_w <<< 2) + DEC_INC_NEG;
      row_adv = row_offset;
    end else begin
      dec_adv = decision + ((col_w - row_w) <<< 2) + DEC_INC_POS;
      row_adv = row_offset - OFF_W'(1);
    end
    inner_inc = inner_row + OFF_W'(1);
    r_c       = COORD_BITS'(radius);
  end

  always_comb begin
    center_col_next = center_col;
    center_row_next = center_row;
    fill_mode_next  = fill_mode;
    col_offset_next = col_offset;
    row_offset_next = row_offset;
    inner_row_next  = inner_row;
    decision_next   = decision;
    phase_next      = phase;
    job.done        = 1'b0;
    job.cx          = center_col;
    job.cy          = center_row;
    job.a           = col_offset;
    job.b           = row_offset;
    if (acc) begin
      if (cmd == CMD_START) begin
        center_col_next = COORD_BITS'(center_x);
        center_row_next = COORD_BITS'(center_y);
        fill_mode_next  = fill;
        col_offset_next = OFF_W'(r_c) & '0;
        row_offset_next = OFF_W'(r_c);
        inner_row_next  = '0;
        decision_next   = DEC_INIT - (DEC_W'(r_c) <<< 1);
        phase_next      = PH_FIRST;
      end else begin
        unique case (phase)
          PH_FIRST: begin
            inner_row_next = col_offset;
            phase_next     = PH_LOOP;
          end
          PH_LOOP: begin
            if (fill_mode) begin
              job.b          = inner_row;
              inner_row_next = inner_inc;
              if (inner_inc > row_offset) begin
                decision_next   = dec_adv;
                row_offset_next = row_adv;
                col_offset_next = col_adv;
                inner_row_next  = col_adv;
              end
            end else begin
              decision_next   = dec_adv;
              row_offset_next = row_adv;
              col_offset_next = col_adv;
            end
            if (col_offset_next > row_offset_next) begin
              phase_next = PH_IDLE;
            end
          end
          default: begin
            job.done = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_col <= '0;
      center_row <= '0;
      fill_mode  <= 1'b0;
      col_offset <= '0;
      row_offset <= '0;
      inner_row  <= '0;
      decision   <= '0;
      phase      <= PH_IDLE;
    end else begin
      center_col <= center_col_next;
      center_row <= center_row_next;
      fill_mode  <= fill_mode_next;
      col_offset <= col_offset_next;
      row_offset <= row_offset_next;
      inner_row  <= inner_row_next;
      decision   <= decision_next;
      phase      <= phase_next;
    end
  end

endmodule

// ----- hdl/cpg_emit.sv -----
module cpg_emit
  import cpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_load,
  input  job_t                  job_in,
  output logic                  take,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  output logic                  m_tuser
);

  logic       jvalid;
  job_t       job;
  logic [2:0] k;

  logic                    out_ld, fire, ending, swap;
  logic signed [OFF_W-1:0] u, v;
  logic [PIX_W-1:0]        px, py, cxw, cyw, uw, vw;

  assign out_ld = !m_tvalid || m_tready;
  assign fire   = jvalid && out_ld;
  assign ending = fire && (job.done || (k == 3'd7));
  assign take   = !jvalid || ending;

  // point k of the eight-way symmetric set
  always_comb begin
    swap = k[2];
    u    = swap ? job.b : job.a;
    v    = swap ? job.a : job.b;
    cxw  = PIX_W'(job.cx);
    cyw  = PIX_W'(job.cy);
    uw   = PIX_W'(u);
    vw   = PIX_W'(v);
    px   = k[1] ? (cxw - uw) : (cxw + uw);
    py   = (k[1] ^ k[0]) ? (cyw - vw) : (cyw + vw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jvalid   <= 1'b0;
      k        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (out_ld) begin
        m_tvalid <= 1'b0;
      end
      if (job_load) begin
        jvalid <= 1'b1;
        k      <= '0;
      end else if (fire) begin
        k <= k + 3'd1;
        if (ending) begin
          jvalid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job <= job_in;
    end
    if (fire) begin
      if (job.done) begin
        m_tdata <= '0;
        m_tlast <= 1'b1;
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= OUT_DATA_W'({py, px});
        m_tlast <= (k == 3'd7);
        m_tuser <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/circle_pixel_generator.sv -----
// channel  dir  tdata                                      tlast      tuser
// s_       in   center_x, center_y, radius, fill (40 bit)  -          cmd
// m_       out  pixel_x, pixel_y (32 bit)                  last       done_res
//
// A step request yields eight pixels, one per cycle while m_tready is high, or one done result.
// The single output register paces steps; the next step is taken as the last pixel is sent.
// A start request is held off while a point set drains.
// rst is synchronous and returns the block to idle (steps report done).
// m_tready low stalls the output register; the pending set and s_tready wait.
module circle_pixel_generator
  import cpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // center_x, center_y, radius, fill, zero pad
  input  logic                  s_tuser,  // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // pixel_x, pixel_y, zero pad
  output logic                  m_tlast,
  output logic                  m_tuser   // done_res
);

  logic acc, job_load, take;
  job_t job;

  assign s_tready = take;
  assign acc      = s_tvalid && take;

  cpg_step u_step (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .cmd      (s_tuser),
    .center_x (s_tdata[11:0]),
    .center_y (s_tdata[23:12]),
    .radius   (s_tdata[35:24]),
    .fill     (s_tdata[36]),
    .job_load (job_load),
    .job      (job)
  );

  cpg_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .job_load (job_load),
    .job_in   (job),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- hdl/cpg_checker.sv -----
module cpg_checker
  import cpg_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast,
  input logic                  m_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed under stall");

  // done result is a single, last result
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("done result without last");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("done result carries pixel data");

  // pixels of one set follow without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside a point set");

endmodule

bind circle_pixel_generator cpg_checker u_cpg_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
